// ===== design/median_of_25_network_defines.svh =====
// Assertion macros used by the checker file of the median block.
`ifndef MEDIAN_OF_25_NETWORK_DEFINES_SVH
`define MEDIAN_OF_25_NETWORK_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define M25_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("median_of_25_network: check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define M25_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("median_of_25_network: check failed");

`endif

// ===== design/m25_pkg.sv =====
// Package: widths, types, FSM codes and the compare-exchange schedule.
`timescale 1ns / 1ps
`default_nettype none
package m25_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int WIN_SIZE     = 25;
    localparam int NET_STEPS    = 99;
    localparam int ADDR_W       = $clog2(WIN_SIZE);
    localparam int STEP_W       = $clog2(NET_STEPS);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [ADDR_W-1:0]              addr_t;
    typedef logic [STEP_W-1:0]              step_t;

    localparam addr_t MID_ADDR  = addr_t'(12);
    localparam addr_t LAST_ADDR = addr_t'(WIN_SIZE - 1);
    localparam step_t LAST_STEP = step_t'(NET_STEPS - 1);

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_READ  = 6'b000010,
        S_CMP   = 6'b000100,
        S_WRB   = 6'b001000,
        S_FETCH = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    // Pair positions, 1-based; after each step w[a] <= w[b].
    localparam int unsigned NET_A [NET_STEPS] = '{
        1, 4, 3, 3, 7,    6, 6, 10, 9, 9,    13, 12, 12, 16, 15,
        15, 19, 18, 18, 22,    21, 21, 24, 3, 4,    1, 1, 5, 2, 2,
        12, 9, 9, 13, 10,    10, 14, 11, 11, 21,    18, 18, 22, 19, 19,
        20, 9, 10, 1, 1,    11, 2, 2, 12, 3,    3, 13, 4, 4, 14,
        5, 5, 15, 6, 6,    16, 7, 7, 8, 8,    14, 16, 8, 8, 2,
        4, 6, 12, 10, 5,    7, 8, 5, 5, 13,    11, 7, 11, 7, 7,
        13, 8, 8, 13, 8,    11, 13, 11, 11
    };

    localparam int unsigned NET_B [NET_STEPS] = '{
        2, 5, 5, 4, 8,    8, 7, 11, 11, 10,    14, 14, 13, 17, 17,
        16, 20, 20, 19, 23,    23, 22, 25, 6, 7,    7, 4, 8, 8, 5,
        15, 15, 12, 16, 16,    13, 17, 17, 14, 24,    24, 21, 25, 25, 22,
        23, 18, 19, 19, 10,    20, 20, 11, 21, 21,    12, 22, 22, 13, 23,
        23, 14, 24, 24, 15,    25, 25, 16, 17, 20,    22, 24, 14, 16, 10,
        12, 18, 18, 18, 11,    13, 15, 7, 8, 15,    15, 8, 13, 11, 18,
        18, 18, 11, 19, 13,    19, 21, 21, 13
    };

    function automatic addr_t pair_lo(input step_t s);
        return addr_t'(NET_A[s] - 1);
    endfunction

    function automatic addr_t pair_hi(input step_t s);
        return addr_t'(NET_B[s] - 1);
    endfunction

endpackage
`default_nettype wire

// ===== design/m25_sample_if.sv =====
// Sample channel: valid/ready handshake with one signed sample per beat.
`timescale 1ns / 1ps
`default_nettype none
interface m25_sample_if;
    logic             valid;
    logic             ready;
    m25_pkg::sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

// ===== design/m25_median_if.sv =====
// Median channel: valid/ready handshake with one signed median per beat.
`timescale 1ns / 1ps
`default_nettype none
interface m25_median_if;
    logic             valid;
    logic             ready;
    m25_pkg::sample_t median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface
`default_nettype wire

// ===== design/m25_ram.sv =====
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module m25_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 25
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

// ===== design/m25_cx.sv =====
// Shared compare-exchange unit: min goes out at once, max is registered while hold is high.
`timescale 1ns / 1ps
`default_nettype none
module m25_cx (
    input  wire logic             clk,
    input  wire m25_pkg::sample_t a,
    input  wire m25_pkg::sample_t b,
    input  wire logic             hold,
    output m25_pkg::sample_t      lo,
    output m25_pkg::sample_t      hi
);

    logic             swap;
    m25_pkg::sample_t hi_reg;
    m25_pkg::sample_t hi_next;

    assign swap    = (b < a);
    assign lo      = swap ? b : a;
    assign hi_next = swap ? a : b;
    assign hi      = hi_reg;

    always_ff @(posedge clk)
    begin
        if (hold)
        begin
            hi_reg <= hi_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/median_of_25_network.sv =====
// Top level: 5x5 window median by a 99-step compare-exchange network.
//
// samples (sink): one signed 16-bit sample per beat, row-major, 25 per window.
// medians (source): one median beat per completed window.
// All 25 samples are written into a 25-entry RAM, one per cycle while
// samples.ready is high. On the 25th, ready drops and a sequencer walks the
// 99 compare-exchange steps through one shared compare unit, each step
// passing S_READ (read pair), S_CMP (write min) and S_WRB (write max).
// Position 13 is then read back through S_FETCH and S_EMIT into the output
// register; no new sample is accepted until that median is captured.
// The median register parts the two sides: loading of the next window goes
// on while a median waits. If the receiver still holds the previous median
// when the next one is ready, the block waits with samples.ready low.
// rst_n (asynchronous, active low) empties the window and the output
// register; RAM contents are not cleared and need not be.
`timescale 1ns / 1ps
`default_nettype none
module median_of_25_network (
    input  wire logic    clk,
    input  wire logic    rst_n,
    m25_sample_if.sink   samples,
    m25_median_if.source medians
);

    m25_pkg::state_t  state_reg, state_next;
    m25_pkg::addr_t   fill_reg, fill_next;
    m25_pkg::step_t   step_reg, step_next;
    logic             out_valid_reg, out_valid_next;
    m25_pkg::sample_t median_reg;
    logic             capture;

    logic             accept;
    logic             we;
    m25_pkg::addr_t   waddr;
    m25_pkg::sample_t wdata;
    m25_pkg::addr_t   raddr_a;
    m25_pkg::addr_t   pa;
    m25_pkg::addr_t   pb;
    m25_pkg::sample_t rd_a;
    m25_pkg::sample_t rd_b;
    m25_pkg::sample_t lo;
    m25_pkg::sample_t hi;

    assign samples.ready = (state_reg == m25_pkg::S_LOAD);
    assign accept        = samples.valid && samples.ready;
    assign medians.valid = out_valid_reg;
    assign medians.median = median_reg;

    assign pa = m25_pkg::pair_lo(step_reg);
    assign pb = m25_pkg::pair_hi(step_reg);
    assign raddr_a = (state_reg inside {m25_pkg::S_FETCH, m25_pkg::S_EMIT})
                     ? m25_pkg::MID_ADDR : pa;

    always_comb
    begin
        we    = 1'b0;
        waddr = fill_reg;
        wdata = samples.sample;
        case (state_reg)
            m25_pkg::S_LOAD:
            begin
                we = accept;
            end
            m25_pkg::S_CMP:
            begin
                we    = 1'b1;
                waddr = pa;
                wdata = lo;
            end
            m25_pkg::S_WRB:
            begin
                we    = 1'b1;
                waddr = pb;
                wdata = hi;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        step_next  = step_reg;
        capture    = 1'b0;
        case (state_reg)
            m25_pkg::S_LOAD:
            begin
                if (accept)
                begin
                    if (fill_reg == m25_pkg::LAST_ADDR)
                    begin
                        fill_next  = '0;
                        step_next  = '0;
                        state_next = m25_pkg::S_READ;
                    end
                    else
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            m25_pkg::S_READ:
            begin
                state_next = m25_pkg::S_CMP;
            end
            m25_pkg::S_CMP:
            begin
                state_next = m25_pkg::S_WRB;
            end
            m25_pkg::S_WRB:
            begin
                if (step_reg == m25_pkg::LAST_STEP)
                begin
                    state_next = m25_pkg::S_FETCH;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = m25_pkg::S_READ;
                end
            end
            m25_pkg::S_FETCH:
            begin
                state_next = m25_pkg::S_EMIT;
            end
            m25_pkg::S_EMIT:
            begin
                if (!out_valid_reg || medians.ready)
                begin
                    capture    = 1'b1;
                    state_next = m25_pkg::S_LOAD;
                end
            end
            default:
            begin
                state_next = m25_pkg::S_LOAD;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (medians.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= m25_pkg::S_LOAD;
            fill_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            median_reg <= rd_a;
        end
    end

    m25_ram #(
        .WIDTH (m25_pkg::SAMPLE_WIDTH),
        .DEPTH (m25_pkg::WIN_SIZE)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (pb),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // min written back in the compare cycle, max latched for the next one
    m25_cx u_cx (
        .clk  (clk),
        .a    (rd_a),
        .b    (rd_b),
        .hold (state_reg == m25_pkg::S_CMP),
        .lo   (lo),
        .hi   (hi)
    );

endmodule
`default_nettype wire

// ===== design/m25_checker.sv =====
// Port checker for the median block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "median_of_25_network_defines.svh"
module m25_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire m25_pkg::sample_t out_median
);

    m25_pkg::addr_t cnt_reg, cnt_next;
    logic           in_beat;
    logic           last_beat;

    assign in_beat   = in_valid && in_ready;
    assign last_beat = in_beat && (cnt_reg == m25_pkg::LAST_ADDR);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (last_beat)
        begin
            cnt_next = '0;
        end
        else if (in_beat)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    `M25_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `M25_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_median))
    `M25_ASSERT_NEXT(a_busy_after_window, last_beat, !in_ready)
    `M25_ASSERT_NOW(a_median_after_busy, $rose(out_valid), !$past(in_ready))

endmodule

bind median_of_25_network m25_checker u_m25_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (samples.valid),
    .in_ready   (samples.ready),
    .out_valid  (medians.valid),
    .out_ready  (medians.ready),
    .out_median (medians.median)
);
`default_nettype wire
